>>> rtl/core/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, codes and the crc-16 byte update for the modbus rtu
// response checker.
// ----------------------------------------------------------------------------
package mrrc_pkg;

	localparam int FRAME_MAX = 256;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  EXC_BIT  = 8'h80;

	localparam logic [6:0] FN_READ_COILS    = 7'd1;
	localparam logic [6:0] FN_READ_INPUTS   = 7'd2;
	localparam logic [6:0] FN_READ_HOLDING  = 7'd3;
	localparam logic [6:0] FN_READ_INPUT_RG = 7'd4;

	localparam logic [1:0] REG_SLAVE    = 2'd0;
	localparam logic [1:0] REG_FUNCTION = 2'd1;
	localparam logic [1:0] REG_QUANTITY = 2'd2;

	typedef enum logic [3:0] {
		ST_PENDING   = 4'd0,
		ST_OK        = 4'd1,
		ST_SLAVE     = 4'd2,
		ST_FUNCTION  = 4'd3,
		ST_BYTECOUNT = 4'd4,
		ST_TOO_LONG  = 4'd5,
		ST_EXCEPTION = 4'd6,
		ST_CRC       = 4'd7,
		ST_IGNORED   = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RECV = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EE_NONE     = 2'd0,
		EE_SLAVE    = 2'd1,
		EE_FUNCTION = 2'd2
	} early_t;

	typedef struct packed {
		logic [7:0]  expected_slave;
		logic [6:0]  request_function;
		logic [15:0] request_quantity;
	} cfg_t;

	typedef struct packed {
		status_t     status;
		logic        frame_done;
		logic [7:0]  exc_code;
		logic        is_payload;
		logic [7:0]  payload_byte;
	} res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/core/mrrc_frame.sv
// ----------------------------------------------------------------------------
// mrrc_frame
// Frame state of the response checker: header compare, length tracking,
// running crc and the per-byte result, one byte per transfer.
// ----------------------------------------------------------------------------
module mrrc_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  mrrc_pkg::cfg_t cfg,
	input  logic          in_fire,
	input  logic [7:0]    rx_byte,
	input  logic          frame_start,
	output mrrc_pkg::res_t res
);
	import mrrc_pkg::*;

	localparam int CNT_W = 18;

	logic [8:0]  byte_index_q, byte_index_d;
	logic [15:0] crc_q, crc_d;
	logic [8:0]  flen_q, flen_d;
	phase_t      phase_q, phase_d;
	logic        exc_flag_q, exc_flag_d;
	logic [7:0]  exc_val_q, exc_val_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	early_t      early_q, early_d;

	logic [CNT_W-1:0] want;
	logic             is_read;
	logic [9:0]       idx_p2;

	always_comb begin
		is_read = (cfg.request_function == FN_READ_COILS) ||
			(cfg.request_function == FN_READ_INPUTS) ||
			(cfg.request_function == FN_READ_HOLDING) ||
			(cfg.request_function == FN_READ_INPUT_RG);
		if (cfg.request_function <= FN_READ_INPUTS) begin
			want = CNT_W'(({1'b0, cfg.request_quantity} + 17'd7) >> 3);
		end else begin
			want = {1'b0, cfg.request_quantity, 1'b0};
		end
	end

	always_comb begin
		byte_index_d = byte_index_q;
		crc_d        = crc_q;
		flen_d       = flen_q;
		phase_d      = phase_q;
		exc_flag_d   = exc_flag_q;
		exc_val_d    = exc_val_q;
		crc_lo_d     = crc_lo_q;
		early_d      = early_q;
		res          = '{status: ST_PENDING, frame_done: 1'b0, exc_code: 8'h00,
			is_payload: 1'b0, payload_byte: 8'h00};

		if (frame_start) begin
			byte_index_d = '0;
			crc_d        = CRC_INIT;
			flen_d       = '0;
			exc_flag_d   = 1'b0;
			exc_val_d    = '0;
			crc_lo_d     = '0;
			early_d      = EE_NONE;
			phase_d      = PH_RECV;
		end

		idx_p2 = {1'b0, byte_index_d} + 10'd2;

		if (phase_d != PH_RECV) begin
			res.status = ST_IGNORED;
		end else begin
			priority if (byte_index_d == 9'd0) begin
				if (rx_byte != cfg.expected_slave) early_d = EE_SLAVE;
			end else if (byte_index_d == 9'd1) begin
				if (early_d == EE_NONE && rx_byte != {1'b0, cfg.request_function}) begin
					if (rx_byte == ({1'b0, cfg.request_function} | EXC_BIT)) begin
						exc_flag_d = 1'b1;
						flen_d     = 9'd5;
					end else begin
						early_d = EE_FUNCTION;
					end
				end
			end else if (byte_index_d == 9'd2) begin
				priority if (early_d == EE_SLAVE) begin
					res.status     = ST_SLAVE;
					res.frame_done = 1'b1;
				end else if (early_d == EE_FUNCTION) begin
					res.status     = ST_FUNCTION;
					res.frame_done = 1'b1;
				end else if (exc_flag_d) begin
					exc_val_d = rx_byte;
				end else if (is_read) begin
					if ({10'd0, rx_byte} != want) begin
						res.status     = ST_BYTECOUNT;
						res.frame_done = 1'b1;
					end else if (want + CNT_W'(5) > CNT_W'(FRAME_MAX)) begin
						res.status     = ST_TOO_LONG;
						res.frame_done = 1'b1;
					end else begin
						flen_d = 9'(want + CNT_W'(5));
					end
				end else begin
					flen_d = 9'd8;
				end
			end else begin
			end

			if (!res.frame_done) begin
				priority if (byte_index_d < 9'd3 || idx_p2 < {1'b0, flen_d}) begin
					crc_d = crc16_byte(crc_d, rx_byte);
					if (byte_index_d >= 9'd3 && !exc_flag_d) begin
						res.is_payload   = 1'b1;
						res.payload_byte = rx_byte;
					end
				end else if (idx_p2 == {1'b0, flen_d}) begin
					crc_lo_d = rx_byte;
				end else begin
					res.frame_done = 1'b1;
					if (exc_flag_d) begin
						res.status   = ST_EXCEPTION;
						res.exc_code = exc_val_d;
					end else begin
						res.status = ({rx_byte, crc_lo_d} == crc_d) ? ST_OK : ST_CRC;
					end
				end
			end

			if (res.frame_done) begin
				phase_d = PH_DONE;
			end else begin
				byte_index_d = byte_index_d + 9'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q        <= CRC_INIT;
			flen_q       <= '0;
			phase_q      <= PH_IDLE;
			exc_flag_q   <= 1'b0;
			exc_val_q    <= '0;
			crc_lo_q     <= '0;
			early_q      <= EE_NONE;
		end else if (in_fire) begin
			byte_index_q <= byte_index_d;
			crc_q        <= crc_d;
			flen_q       <= flen_d;
			phase_q      <= phase_d;
			exc_flag_q   <= exc_flag_d;
			exc_val_q    <= exc_val_d;
			crc_lo_q     <= crc_lo_d;
			early_q      <= early_d;
		end
	end

endmodule

>>> rtl/core/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// Checks a modbus rtu response byte by byte against the programmed request.
// ----------------------------------------------------------------------------
// Every received byte gives one result. A byte is taken in every cycle while
// in_stall is low and its result is registered; the rate of one byte per cycle
// is set by the combinational crc-16 byte update and header compare in the
// frame stage. A two-entry output (result register plus skid register) keeps
// the input open while one result waits; in_stall rises only when both are
// full. Program expected_slave (0x0), request_function (0x4) and
// request_quantity (0x8) over the apb port while no frame is in flight.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic        frame_done,
	output logic [7:0]  exc_code,
	output logic        is_payload,
	output logic [7:0]  payload_byte
);
	import mrrc_pkg::*;

	cfg_t cfg_q;
	res_t step_res;
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic in_fire, out_fire, cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_slave   <= 8'hFF;
			cfg_q.request_function <= '0;
			cfg_q.request_quantity <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SLAVE:    cfg_q.expected_slave   <= pwdata[7:0];
				REG_FUNCTION: cfg_q.request_function <= pwdata[6:0];
				REG_QUANTITY: cfg_q.request_quantity <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SLAVE:    prdata = {24'd0, cfg_q.expected_slave};
			REG_FUNCTION: prdata = {25'd0, cfg_q.request_function};
			REG_QUANTITY: prdata = {16'd0, cfg_q.request_quantity};
			default:      prdata = '0;
		endcase
	end

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	mrrc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_fire     (in_fire),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.res         (step_res)
	);

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : step_res;
		end else if (in_fire) begin
			skid_q <= step_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign frame_done   = out_q.frame_done;
	assign exc_code     = out_q.exc_code;
	assign is_payload   = out_q.is_payload;
	assign payload_byte = out_q.payload_byte;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a result in the output register");

	a_ok_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_q.status == ST_OK || out_q.status == ST_CRC ||
		out_q.status == ST_EXCEPTION) |-> frame_done)
		else $error("final status without frame_done");

	a_exc_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exc_code != 8'h00 |-> out_q.status == ST_EXCEPTION)
		else $error("exception code on a non-exception result");

	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_payload |-> out_q.status == ST_PENDING && !frame_done)
		else $error("payload byte on a finished or ignored result");

endmodule

>>> bench/tb_modbus_rtu_response_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_checker
// Self-checking bench for the modbus rtu response checker. A short directed
// pass covers good, exception, rejected and restarted frames, then random
// frames (mostly well formed, some damaged, cut short or stray) run under
// nine request settings and four idle/stall mixes. A byte-level model of the
// checker predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_checker;
	import mrrc_pkg::*;

	class frame_verdict_board;
		logic [7:0]  slave_addr;
		logic [6:0]  func_code;
		logic [15:0] quantity;

		logic [8:0]  idx;
		logic [15:0] crc;
		int          flen;
		phase_t      rx_state;
		logic        exc_flag;
		logic [7:0]  exc_val;
		logic [7:0]  crc_lo;
		early_t      early;

		res_t        expected_verdicts[$];
		int          faults;

		function new();
			slave_addr = 8'hFF;
			func_code  = '0;
			quantity   = '0;
			idx        = '0;
			crc        = CRC_INIT;
			flen       = 0;
			rx_state   = PH_IDLE;
			exc_flag   = 1'b0;
			exc_val    = '0;
			crc_lo     = '0;
			early      = EE_NONE;
			faults     = 0;
		endfunction

		static function logic [15:0] crc_fold(logic [15:0] c, logic [7:0] d);
			logic [15:0] r;
			r = c ^ {8'h00, d};
			repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
			return r;
		endfunction

		function void write_register(logic [1:0] sel, logic [31:0] v);
			case (sel)
				REG_SLAVE:    slave_addr = v[7:0];
				REG_FUNCTION: func_code = v[6:0];
				REG_QUANTITY: quantity = v[15:0];
				default: ;
			endcase
		endfunction

		function status_t note_byte(logic [7:0] b, logic s);
			res_t r;
			int   i;
			int   want;
			logic done;
			logic [7:0] fn;
			r = '0;
			r.status = ST_PENDING;
			done = 1'b0;
			fn = {1'b0, func_code};
			if (s) begin
				idx = '0;
				crc = CRC_INIT;
				flen = 0;
				exc_flag = 1'b0;
				exc_val = '0;
				crc_lo = '0;
				early = EE_NONE;
				rx_state = PH_RECV;
			end
			if (rx_state != PH_RECV) begin
				r.status = ST_IGNORED;
			end else begin
				i = int'(idx);
				if (i == 0) begin
					if (b != slave_addr) early = EE_SLAVE;
				end else if (i == 1) begin
					if (early == EE_NONE && b != fn) begin
						if (b == (fn | EXC_BIT)) begin
							exc_flag = 1'b1;
							flen = 5;
						end else begin
							early = EE_FUNCTION;
						end
					end
				end else if (i == 2) begin
					if (early == EE_SLAVE) begin
						r.status = ST_SLAVE;
						done = 1'b1;
					end else if (early == EE_FUNCTION) begin
						r.status = ST_FUNCTION;
						done = 1'b1;
					end else if (exc_flag) begin
						exc_val = b;
					end else if (func_code == FN_READ_COILS || func_code == FN_READ_INPUTS ||
						func_code == FN_READ_HOLDING || func_code == FN_READ_INPUT_RG) begin
						want = (func_code <= FN_READ_INPUTS) ? (int'(quantity) + 7) / 8
							: int'(quantity) * 2;
						if (int'(b) != want) begin
							r.status = ST_BYTECOUNT;
							done = 1'b1;
						end else if (want + 5 > FRAME_MAX) begin
							r.status = ST_TOO_LONG;
							done = 1'b1;
						end else begin
							flen = want + 5;
						end
					end else begin
						flen = 8;
					end
				end
				if (!done) begin
					if (i < 3 || i + 2 < flen) begin
						crc = crc_fold(crc, b);
						if (i >= 3 && !exc_flag) begin
							r.is_payload = 1'b1;
							r.payload_byte = b;
						end
					end else if (i + 2 == flen) begin
						crc_lo = b;
					end else begin
						done = 1'b1;
						if (exc_flag) begin
							r.status = ST_EXCEPTION;
							r.exc_code = exc_val;
						end else begin
							r.status = ({b, crc_lo} == crc) ? ST_OK : ST_CRC;
						end
					end
				end
				if (done) rx_state = PH_DONE;
				else idx = idx + 9'd1;
			end
			r.frame_done = done;
			expected_verdicts.push_back(r);
			return r.status;
		endfunction

		function void check_verdict(res_t got);
			res_t want;
			if (expected_verdicts.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: st=%0d done=%0b exc=%h pay=%0b byte=%h",
						got.status, got.frame_done, got.exc_code, got.is_payload,
						got.payload_byte);
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.status != want.status || got.frame_done != want.frame_done ||
				got.exc_code != want.exc_code ||
				got.is_payload != want.is_payload || got.payload_byte != want.payload_byte) begin
				faults++;
				if (faults <= 10) begin
					$display("mismatch: exp st=%0d done=%0b exc=%h pay=%0b byte=%h",
						want.status, want.frame_done, want.exc_code, want.is_payload,
						want.payload_byte);
					$display("          got st=%0d done=%0b exc=%h pay=%0b byte=%h",
						got.status, got.frame_done, got.exc_code, got.is_payload,
						got.payload_byte);
				end
			end
		endfunction

		function void close_out();
			if (expected_verdicts.size() != 0) begin
				faults++;
				$display("%0d expected results never arrived", expected_verdicts.size());
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_SETTINGS  = 9;
	localparam int PHASE_ITEMS = 110;

	localparam logic [7:0]  PLAN_SLAVE [N_SETTINGS] =
		'{8'h11, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h7E, 8'h33, 8'hC3};
	localparam logic [6:0]  PLAN_FUNC  [N_SETTINGS] =
		'{7'd3, 7'd1, 7'd6, 7'd4, 7'd2, 7'd127, 7'd0, 7'd3, 7'd1};
	localparam logic [15:0] PLAN_QTY   [N_SETTINGS] =
		'{16'd2, 16'd13, 16'd0, 16'd126, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd2001};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  status;
	logic        frame_done;
	logic [7:0]  exc_code;
	logic        is_payload;
	logic [7:0]  payload_byte;

	frame_verdict_board tracker;
	logic [7:0] frame_buf[$];
	int send_idle = 0;
	int recv_stall = 0;
	int counted_items = 0;
	int cycle_count = 0;

	modbus_rtu_response_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.frame_start(frame_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.frame_done(frame_done),
		.exc_code(exc_code),
		.is_payload(is_payload),
		.payload_byte(payload_byte)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin : result_side
		res_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.status = status_t'(status);
				seen.frame_done = frame_done;
				seen.exc_code = exc_code;
				seen.is_payload = is_payload;
				seen.payload_byte = payload_byte;
				tracker.check_verdict(seen);
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall);
		end
	end

	task automatic apb_write(input logic [1:0] sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_register(sel, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_request(input logic [7:0] slave, input logic [6:0] fn,
		input logic [15:0] qty);
		apb_write(REG_SLAVE, {24'($urandom), slave});
		apb_write(REG_FUNCTION, {25'($urandom), fn});
		apb_write(REG_QUANTITY, {16'($urandom), qty});
	endtask

	task automatic send_byte(input logic [7:0] b, input logic s);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= s;
		do @(posedge clk); while (in_stall);
		if (tracker.note_byte(b, s) != ST_IGNORED) counted_items++;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_verdicts.size() != 0);
	endtask

	task automatic seal_frame();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_buf[k]) c = tracker.crc_fold(c, frame_buf[k]);
		frame_buf.push_back(c[7:0]);
		frame_buf.push_back(c[15:8]);
	endtask

	task automatic send_frame();
		foreach (frame_buf[k]) send_byte(frame_buf[k], k == 0);
	endtask

	task automatic run_random_frame();
		int pick, want, dlen, n, k;
		logic [7:0] fn;
		frame_buf.delete();
		fn = {1'b0, tracker.func_code};
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// stray bytes with no frame start
			n = $urandom_range(1, 3);
			repeat (n) send_byte(8'($urandom), 1'b0);
			return;
		end
		if (pick < 14) begin
			n = $urandom_range(1, 12);
			repeat (n) frame_buf.push_back(8'($urandom));
		end else begin
			frame_buf.push_back(tracker.slave_addr);
			if (pick < 26) begin
				frame_buf.push_back(fn | EXC_BIT);
				frame_buf.push_back(8'($urandom));
			end else if (tracker.func_code == FN_READ_COILS ||
				tracker.func_code == FN_READ_INPUTS ||
				tracker.func_code == FN_READ_HOLDING ||
				tracker.func_code == FN_READ_INPUT_RG) begin
				want = (tracker.func_code <= FN_READ_INPUTS) ?
					(int'(tracker.quantity) + 7) / 8 : int'(tracker.quantity) * 2;
				frame_buf.push_back(fn);
				frame_buf.push_back(8'(want));
				dlen = (want <= 251) ? want : $urandom_range(0, 3);
				repeat (dlen) frame_buf.push_back(8'($urandom));
			end else begin
				frame_buf.push_back(fn);
				repeat (4) frame_buf.push_back(8'($urandom));
			end
			seal_frame();
			if (pick >= 80 && pick < 90) begin
				k = $urandom_range(0, frame_buf.size() - 1);
				frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
			end else if (pick >= 90 && pick < 95) begin
				k = $urandom_range(0, 1);
				frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
			end else if (pick >= 95) begin
				// cut short, the next frame start restarts it
				n = $urandom_range(1, frame_buf.size() - 1);
				while (frame_buf.size() > n) void'(frame_buf.pop_back());
			end
		end
		send_frame();
	endtask

	initial begin
		int base;
		logic first;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_request(8'h11, FN_READ_HOLDING, 16'd1);
		// restart inside a frame
		frame_buf = '{8'h11, 8'h03};
		send_frame();
		frame_buf = '{8'h11, 8'h03, 8'h02, 8'h00, 8'hFF};
		seal_frame();
		send_frame();
		send_byte(8'hFF, 1'b0);
		frame_buf = '{8'h11, 8'h83, 8'hFF};
		seal_frame();
		send_frame();
		// slave and function both wrong
		frame_buf = '{8'h00, 8'h05, 8'h02};
		send_frame();
		frame_buf = '{8'h11, 8'h05, 8'h02};
		send_frame();
		frame_buf = '{8'h11, 8'h03, 8'h03};
		send_frame();
		wait_results_done();
		apb_write(REG_QUANTITY, 32'd126);
		frame_buf = '{8'h11, 8'h03, 8'hFC};
		send_frame();

		for (int p = 0; p < N_SETTINGS; p++) begin
			wait_results_done();
			program_request(PLAN_SLAVE[p], PLAN_FUNC[p], PLAN_QTY[p]);
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 85; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 85; end
				default: begin send_idle = 31; recv_stall = 31; end
			endcase
			base = counted_items;
			first = 1'b1;
			while (counted_items - base < PHASE_ITEMS) begin
				run_random_frame();
				if (first) begin
					wait_results_done();
					first = 1'b0;
				end
			end
		end

		wait_results_done();
		repeat (16) @(posedge clk);
		tracker.close_out();
		if (tracker.faults == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/mrrc_pkg.sv
rtl/core/mrrc_frame.sv
rtl/core/modbus_rtu_response_checker.sv
bench/tb_modbus_rtu_response_checker.sv
